/* hw/rtl/swda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swda_pkg: shared types and constants of the sliding window average
// Sizes, the queued work item, the back end state encoding and the
// ring pointer increment.
// ----------------------------------------------------------------------------
package swda_pkg;

  localparam int FIFO_DEPTH  = 1024;
  localparam int SAMPLE_BITS = 40;

  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int LIMIT_W   = 11;
  localparam int SUM_W     = 50;
  localparam int AVG_W     = 48;
  localparam int FRAC_BITS = 8;
  localparam int DIV_W     = SUM_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(DIV_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // one queued sample with the window limit already resolved
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CNT_W-1:0]       limit;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SUB,
    ST_APPEND,
    ST_CHK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } back_state_e;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

/* hw/rtl/swda_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swda_front: input side of the sliding window average
// Holds the window limit register, resolves the effective limit for each
// sample and buffers samples in a short queue toward the back end.
// ----------------------------------------------------------------------------
module swda_front
  import swda_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] duration_sample_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LIMIT_W-1:0]     window_limit_i,
  output logic                   item_valid_o,
  input  logic                   item_ready_i,
  output item_t                  item_o
);

  logic [LIMIT_W-1:0] window_limit_q;
  item_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QFILL_W-1:0] fill_q;
  logic               push, pop;
  logic [CNT_W-1:0]   limit_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_limit_q <= '0;
    end else if (cfg_valid_i) begin
      window_limit_q <= window_limit_i;
    end
  end

  // zero or anything above capacity means the full ring
  always_comb begin
    if (window_limit_q == '0 || 32'(window_limit_q) > 32'(FIFO_DEPTH)) begin
      limit_eff = CNT_W'(FIFO_DEPTH);
    end else begin
      limit_eff = CNT_W'(window_limit_q);
    end
  end

  assign in_ready_o   = (fill_q != QFILL_W'(QUEUE_DEPTH));
  assign item_valid_o = (fill_q != '0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{sample: duration_sample_i, limit: limit_eff};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/swda_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swda_div: serial restoring divider
// One quotient bit per cycle; done pulses once when the last bit is in.
// ----------------------------------------------------------------------------
module swda_div
  import swda_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  quot_q;
  logic [CNT_W-1:0]  rem_q, dsor_q;
  logic [CNT_W:0]    trial, diff;
  logic              ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quot_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsor_q};
  assign ge    = (trial >= {1'b0, dsor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DIV_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], ge};
      rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

/* hw/rtl/swda_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swda_back: window engine of the sliding window average
// Owns the sample ring, pointers, count and running sum; appends, drops
// the oldest entries, divides and holds the result in an output register.
// ----------------------------------------------------------------------------
module swda_back
  import swda_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  item_t            item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CNT_W-1:0] entry_count_o,
  output logic [SUM_W-1:0] window_sum_o,
  output logic [AVG_W-1:0] average_q8_o
);

  back_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] ring_mem [FIFO_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q, drop_val;
  logic                   rd_zero_q;
  logic                   slot0_valid_q;

  logic [PTR_W-1:0]       oldest_q, newest_q, wr_addr;
  logic [CNT_W-1:0]       count_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] cur_sample_q;
  logic [CNT_W-1:0]       cur_limit_q;
  logic                   appended_q;

  logic                   out_valid_q;
  logic [CNT_W-1:0]       out_count_q;
  logic [SUM_W-1:0]       out_sum_q;
  logic [AVG_W-1:0]       out_avg_q;

  logic                   take, mem_we, div_start, out_load, out_free, over_limit;
  logic                   div_done;
  logic [DIV_W-1:0]       quotient;
  logic [AVG_W-1:0]       avg_sat;

  assign wr_addr    = ptr_next(newest_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign over_limit = (count_q > cur_limit_q) && (count_q > CNT_W'(1));
  // slot zero reads as zero until first written
  assign drop_val   = rd_zero_q ? '0 : rd_data_q;
  assign avg_sat    = (quotient[DIV_W-1:AVG_W] != '0) ? '1 : quotient[AVG_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = (count_q >= CNT_W'(FIFO_DEPTH)) ? ST_RD : ST_APPEND;
        end
      end
      ST_RD:       state_d = ST_SUB;
      ST_SUB:      state_d = appended_q ? ST_CHK : ST_APPEND;
      ST_APPEND:   state_d = ST_CHK;
      ST_CHK:      state_d = over_limit ? ST_RD : ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: state_d = div_done ? ST_OUT : ST_DIV_WAIT;
      ST_OUT:      state_d = out_free ? ST_IDLE : ST_OUT;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready_o = (state_q == ST_IDLE);
    take         = item_ready_o && item_valid_i;
    mem_we       = (state_q == ST_APPEND);
    div_start    = (state_q == ST_DIV_GO);
    out_load     = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= cur_sample_q;
    end
    rd_data_q <= ring_mem[oldest_q];
    rd_zero_q <= (oldest_q == '0) && !slot0_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      oldest_q      <= '0;
      newest_q      <= '0;
      count_q       <= CNT_W'(1);
      sum_q         <= '0;
      appended_q    <= 1'b0;
      slot0_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        appended_q <= 1'b0;
      end
      if (state_q == ST_SUB) begin
        sum_q    <= sum_q - SUM_W'(drop_val);
        oldest_q <= ptr_next(oldest_q);
        count_q  <= count_q - 1'b1;
      end
      if (mem_we) begin
        newest_q   <= wr_addr;
        count_q    <= count_q + 1'b1;
        sum_q      <= sum_q + SUM_W'(cur_sample_q);
        appended_q <= 1'b1;
        if (wr_addr == '0) begin
          slot0_valid_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_sample_q <= item_i.sample;
      cur_limit_q  <= item_i.limit;
    end
    if (out_load) begin
      out_count_q <= count_q;
      out_sum_q   <= sum_q;
      out_avg_q   <= avg_sat;
    end
  end

  swda_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i ({sum_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o   = out_valid_q;
  assign entry_count_o = out_count_q;
  assign window_sum_o  = out_sum_q;
  assign average_q8_o  = out_avg_q;

endmodule

/* hw/rtl/sliding_window_duration_average_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_duration_average_unit: moving average of duration samples
// Keeps a ring of recent samples with a running sum and reports count, sum
// and Q8 average for every sample.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | in_valid_i, in_ready_o, duration_sample_i | in
//  config    | cfg_valid_i, cfg_ready_o, window_limit_i  | in
//  result    | out_valid_o, out_ready_i, entry_count_o,  | out
//            | window_sum_o, average_q8_o                |
//
//  Per transaction: append, limit check, divide, output; the serial divider
//    dominates. A full ring adds a ring read and subtract first, and each
//    drop down to the window limit a read, subtract and recheck.
//  A two-entry queue takes input transactions while the engine is busy.
//  The result register lets the engine run on until it has its next result.
//  Reset: ring holds one zero entry, count 1, sum 0, limit 0 (unlimited).
//  Config is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_duration_average_unit
  import swda_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] duration_sample_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LIMIT_W-1:0]     window_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CNT_W-1:0]       entry_count_o,
  output logic [SUM_W-1:0]       window_sum_o,
  output logic [AVG_W-1:0]       average_q8_o
);

  // front to back queue interface
  logic  item_valid;
  logic  item_ready;
  item_t item;

  // front: limit register, limit resolution, sample queue
  swda_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .duration_sample_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .window_limit_i,
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // back: ring, drops, divider, result register
  swda_back u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o,
    .out_ready_i,
    .entry_count_o,
    .window_sum_o,
    .average_q8_o
  );

endmodule

/* hw/rtl/swda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swda_checker: port level checks of the sliding window average
// Result stability and arithmetic sanity seen from the top level ports.
// ----------------------------------------------------------------------------
module swda_checker
  import swda_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [CNT_W-1:0]       entry_count_o,
  input logic [SUM_W-1:0]       window_sum_o,
  input logic [AVG_W-1:0]       average_q8_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_sum_o)
      && $stable(entry_count_o) && $stable(average_q8_o))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o != '0 && entry_count_o <= CNT_W'(FIFO_DEPTH))
    else $error("entry count out of range");

  a_single_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_count_o == CNT_W'(1)
      && window_sum_o[SUM_W-1:AVG_W-FRAC_BITS] == '0
    |-> average_q8_o == {window_sum_o[AVG_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}})
    else $error("average of one entry differs from its sum");

  a_avg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> DIV_W'(average_q8_o) <= {window_sum_o, {FRAC_BITS{1'b0}}})
    else $error("average exceeds sum");

endmodule

bind sliding_window_duration_average_unit swda_checker u_swda_checker (.*);

/* dv/swda_window_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swda_window_checker: scoreboard for the sliding window duration average
// Watches the sample, limit and result channels, keeps its own window of
// samples and checks count, sum and Q8 average of every result in order.
// ----------------------------------------------------------------------------
module swda_window_checker
  import swda_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [SAMPLE_BITS-1:0] duration_sample_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [LIMIT_W-1:0]     window_limit_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [CNT_W-1:0]       entry_count_i,
  input  logic [SUM_W-1:0]       window_sum_i,
  input  logic [AVG_W-1:0]       average_q8_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  localparam logic [63:0] AVG_CEIL = (64'd1 << AVG_W) - 64'd1;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [SUM_W-1:0] window_sum;
    logic [AVG_W-1:0] average_q8;
  } window_result_t;

  logic [SAMPLE_BITS-1:0] held_samples [FIFO_DEPTH];
  logic [PTR_W-1:0]       oldest_slot;
  logic [PTR_W-1:0]       newest_slot;
  int unsigned            held;
  logic [SUM_W-1:0]       total;
  logic [LIMIT_W-1:0]     cur_limit;
  int unsigned            fails;
  window_result_t         expected_windows [$];

  function automatic logic [PTR_W-1:0] advance_slot(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % FIFO_DEPTH);
  endfunction

  // one entry always stays in the window
  function automatic void retire_oldest();
    if (held <= 1) return;
    total = total - SUM_W'(held_samples[oldest_slot]);
    oldest_slot = advance_slot(oldest_slot);
    held--;
  endfunction

  function automatic window_result_t advance_window(input logic [SAMPLE_BITS-1:0] s);
    window_result_t r;
    int unsigned    cap;
    logic [63:0]    scaled;
    logic [63:0]    quo;
    cap = cur_limit;
    if (cap == 0 || cap > FIFO_DEPTH) cap = FIFO_DEPTH;
    if (held >= FIFO_DEPTH) retire_oldest();
    newest_slot = advance_slot(newest_slot);
    held_samples[newest_slot] = s;
    held++;
    total = total + SUM_W'(s);
    while (held > cap && held > 1) retire_oldest();
    scaled = 64'(total) << FRAC_BITS;
    quo = scaled / 64'(held);
    if (quo > AVG_CEIL) quo = AVG_CEIL;
    r.entry_count = CNT_W'(held);
    r.window_sum  = total;
    r.average_q8  = AVG_W'(quo);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    window_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < FIFO_DEPTH; i++) held_samples[i] = '0;
      oldest_slot = '0;
      newest_slot = '0;
      held = 1;
      total = '0;
      cur_limit = '0;
      fails = 0;
      expected_windows.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_windows.size() == 0) begin
          $error("result with no sample pending: entry_count %0d", entry_count_i);
          fails++;
        end else begin
          want = expected_windows.pop_front();
          if (entry_count_i !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_i);
            fails++;
          end
          if (window_sum_i !== want.window_sum) begin
            $error("window_sum: expected %0d, got %0d", want.window_sum, window_sum_i);
            fails++;
          end
          if (average_q8_i !== want.average_q8) begin
            $error("average_q8: expected %0d, got %0d", want.average_q8, average_q8_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) cur_limit = window_limit_i;
      if (in_valid_i && in_ready_i)
        expected_windows.push_back(advance_window(duration_sample_i));
      fail_count_o <= fails;
      pending_o <= expected_windows.size();
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sliding window duration average, top of the testbench
// Drives duration samples and window limit writes into the unit, stalls the
// result side at random and takes the verdict from the window checker.
// ----------------------------------------------------------------------------
module tb;
  import swda_pkg::*;

  // Sizing of the run.
  localparam int unsigned RANDOM_ITEMS = 100;   // varied-limit part
  localparam int unsigned FILL_ITEMS   = 1030;  // unlimited window, runs past full
  localparam int unsigned LONG_HOLD    = 1500;  // result side held off, in cycles
  localparam int unsigned SETTLE       = 100;   // quiet cycles after the last result

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] duration_sample_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [LIMIT_W-1:0]     window_limit_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [CNT_W-1:0]       entry_count_o;
  logic [SUM_W-1:0]       window_sum_o;
  logic [AVG_W-1:0]       average_q8_o;

  int unsigned fail_count;
  int unsigned pending;

  // Shared between the sample driver and the result sink.
  logic quiet_mode;   // no idling on either side
  logic hold_arm;     // asks the sink for its one long hold-off

  sliding_window_duration_average_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .duration_sample_i(duration_sample_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .window_limit_i   (window_limit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .entry_count_o    (entry_count_o),
    .window_sum_o     (window_sum_o),
    .average_q8_o     (average_q8_o)
  );

  swda_window_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .duration_sample_i(duration_sample_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .window_limit_i   (window_limit_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .entry_count_i    (entry_count_o),
    .window_sum_i     (window_sum_o),
    .average_q8_i     (average_q8_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop; the slowest legal run is a few ms.
  initial begin
    #25ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 120);
  endfunction

  // Durations: zero, all ones, small, one-hot, and mostly full random.
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_BITS'($urandom_range(0, 255));
      3:       return SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
      default: return raw[SAMPLE_BITS-1:0];
    endcase
  endfunction

  // Window limits: small windows dominate so drops happen often; also
  // unlimited, exactly full and above-capacity settings.
  function automatic logic [LIMIT_W-1:0] rand_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return LIMIT_W'($urandom_range(1, 16));
    if (r < 60) return LIMIT_W'($urandom_range(17, 200));
    if (r < 70) return LIMIT_W'($urandom_range(201, FIFO_DEPTH - 1));
    if (r < 80) return '0;
    if (r < 90) return LIMIT_W'(FIFO_DEPTH);
    return LIMIT_W'($urandom_range(FIFO_DEPTH + 1, (1 << LIMIT_W) - 1));
  endfunction

  // One sample transaction. Valid stays up into the next call when idle is
  // zero, so back-to-back samples never drop valid in between.
  task automatic send_duration(input logic [SAMPLE_BITS-1:0] s, input int unsigned idle);
    in_valid_i <= 1'b1;
    duration_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // Every sample gives exactly one result, so an empty scoreboard means the
  // engine and its queue are idle.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Only called with the unit drained and in_valid low.
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_valid_i <= 1'b1;
    window_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // A run of random samples; ends drained. Now and then the sender also
  // stops mid-run until every result is back.
  task automatic random_burst(input int unsigned n, input bit quiet);
    int unsigned k;
    int unsigned idle;
    bit          pause;
    for (k = 0; k < n; k++) begin
      idle  = quiet ? 0 : gap_len();
      pause = (k == n - 1) || (!quiet && $urandom_range(0, 59) == 0);
      if (pause && idle == 0) idle = 1;
      send_duration(rand_sample(), idle);
      if (pause) wait_drained();
    end
  endtask

  // Result sink: random stalls, plus one long hold-off counted here while
  // the sender keeps going, so the input queue fills and in_ready drops.
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_done;
    stall_left  = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_arm && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_mode && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    bit          quiet;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    duration_sample_i = '0;
    cfg_valid_i       = 1'b0;
    window_limit_i    = '0;
    quiet_mode        = 1'b0;
    hold_arm          = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset window (limit 0) grows from the single zero entry.
    send_duration('0, 0);
    send_duration('1, 0);
    send_duration(40'hAA_AAAA_AAAA, 2);
    send_duration(40'h55_5555_5555, 0);
    send_duration(40'h00_0000_0001, 1);
    wait_drained();

    // Window of one, written below the current count: first sample drops
    // everything but itself.
    write_limit(LIMIT_W'(1));
    send_duration('1, 0);
    send_duration('0, 0);
    send_duration(40'h80_0000_0000, 1);
    wait_drained();

    // All ones: above capacity, acts as the full ring.
    write_limit('1);
    send_duration('1, 0);
    send_duration(40'd123, 1);
    wait_drained();

    write_limit(LIMIT_W'(FIFO_DEPTH));
    send_duration('1, 3);
    send_duration(40'h7F_FFFF_FFFF, 1);
    wait_drained();

    // Lowered again below the count.
    write_limit(LIMIT_W'(2));
    send_duration(40'd9, 0);
    send_duration('1, 1);
    wait_drained();

    write_limit(LIMIT_W'(FIFO_DEPTH + 1));
    send_duration(40'd77, 1);
    wait_drained();

    // Random phases, each with its own limit and idling style.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_limit(rand_limit());
      n     = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 3) == 0);
      quiet_mode <= quiet;
      random_burst(n, quiet);
      sent += n;
    end

    // Unlimited window run long enough to fill the ring and wrap it; the
    // sink's long hold-off lands at the start of this run.
    write_limit('0);
    quiet_mode <= 1'b0;
    hold_arm   <= 1'b1;
    random_burst(FILL_ITEMS, 1'b0);

    // Full ring under an above-capacity limit: drop then append each time.
    write_limit(LIMIT_W'($urandom_range(FIFO_DEPTH + 1, (1 << LIMIT_W) - 1)));
    random_burst(30, 1'b0);

    write_limit(LIMIT_W'(FIFO_DEPTH));
    quiet_mode <= 1'b1;
    random_burst(20, 1'b1);

    // Big drop: from a full ring down to a handful of entries.
    write_limit(LIMIT_W'($urandom_range(1, 8)));
    quiet_mode <= 1'b0;
    random_burst(20, 1'b0);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
